>>> hw/rtl/iat_pkg.sv
// Package: widths, commands and entry type for the interval attribute table.
`timescale 1ns / 1ps
package iat_pkg;
	localparam int TableEntries = 16;
	localparam int PositionBits = 16;
	localparam int AuthorBits   = 8;
	localparam int StampBits    = 32;
	localparam int IdxBits      = $clog2(TableEntries);
	localparam int CntBits      = $clog2(TableEntries + 1);

	typedef logic [PositionBits-1:0] pos_t;
	typedef logic [IdxBits-1:0]      idx_t;
	typedef logic [CntBits-1:0]      cnt_t;

	localparam pos_t PosMax = {PositionBits{1'b1}};

	typedef enum logic [2:0] {
		CMD_SET    = 3'd0,
		CMD_INSERT = 3'd1,
		CMD_ERASE  = 3'd2,
		CMD_LOOKUP = 3'd3,
		CMD_QUERY  = 3'd4
	} cmd_t;

	typedef struct packed {
		pos_t                  first;
		pos_t                  last;
		logic [1:0]            kind;
		logic [AuthorBits-1:0] author;
		logic [StampBits-1:0]  stamp;
	} entry_t;

	typedef struct packed {
		logic [2:0]            command;
		pos_t                  start_pos;
		pos_t                  end_pos;
		logic [1:0]            change_type;
		logic [AuthorBits-1:0] change_author;
		logic [StampBits-1:0]  change_stamp;
	} req_t;

	typedef struct packed {
		logic [1:0]            found_type;
		logic [AuthorBits-1:0] found_author;
		logic [StampBits-1:0]  found_stamp;
		logic                  any_overlap;
		logic                  table_overflow;
	} rsp_t;

	function automatic pos_t pos_inc(pos_t p);
		return (p == PosMax) ? p : pos_t'(p + 1'b1);
	endfunction
endpackage

>>> hw/rtl/iat_req_if.sv
// Valid/ready channel interface carrying one command.
`timescale 1ns / 1ps
interface iat_req_if;
	import iat_pkg::*;
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/iat_rsp_if.sv
// Valid/ready channel interface carrying one result.
`timescale 1ns / 1ps
interface iat_rsp_if;
	import iat_pkg::*;
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/interval_attribute_table_core.sv
// Interval attribute table: sequenced edit and lookup over a sorted range table.
`timescale 1ns / 1ps
// One command at a time. A command walks the table one entry per cycle unless
// a removal holds or a tidy restart rewinds it; an entry add or drop moves the
// later rows by one place, and each tidy restart rescans from entry zero. Lookup
// and query walk until a hit or the table end, then post the result. Erase and
// insert shift positions and tidy; set and insert then scan, add the new entry,
// scan again and tidy, plus one rescan for every entry that tidy removes.
// in.ready is high only when the block is idle and no result waits.
module interval_attribute_table_core (
	input  logic clk,
	input  logic arst_n,
	iat_req_if.sink   in,
	iat_rsp_if.source out
);
	import iat_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SHIFT, ST_TIDY, ST_SCAN1, ST_ADDNEW, ST_SCAN2,
		ST_LOOK, ST_DONE
	} st_t;

	st_t        state_q;
	entry_t     tab_q [TableEntries];
	cnt_t       count_q;
	cnt_t       i_q;
	req_t       req_q;
	pos_t       s_q, e_q;
	logic [1:0] k_q;
	logic       after_q;   // tidy followed by set (insert) or done
	logic       ovf_q;
	rsp_t       rsp_q;
	logic       ovalid_q;

	entry_t cur, nxt, mrg;
	idx_t   ci;
	logic   has_next;
	assign ci       = idx_t'(i_q);
	assign cur      = tab_q[ci];
	assign nxt      = tab_q[idx_t'(i_q + 1'b1)];
	assign mrg      = '{cur.first, nxt.last, nxt.kind, nxt.author, nxt.stamp};
	assign has_next = (i_q + 1'b1) < count_q;

	assign in.ready  = (state_q == ST_IDLE) && !ovalid_q;
	assign out.valid = ovalid_q;
	assign out.data  = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			i_q      <= '0;
			ovalid_q <= 1'b0;
			ovf_q    <= 1'b0;
			after_q  <= 1'b0;
			for (int j = 0; j < TableEntries; j++) tab_q[j] <= '0;
		end else begin
			if (out.valid && out.ready) ovalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in.valid && in.ready) begin
						req_q   <= in.data;
						s_q     <= in.data.start_pos;
						e_q     <= in.data.end_pos;
						k_q     <= (in.data.change_type == 2'd3) ? 2'd0 : in.data.change_type;
						ovf_q   <= 1'b0;
						i_q     <= '0;
						rsp_q   <= '0;
						case (in.data.command)
							CMD_SET: begin
								if (in.data.end_pos <= in.data.start_pos) state_q <= ST_DONE;
								else state_q <= ST_SCAN1;
							end
							CMD_INSERT: begin
								after_q <= 1'b1;
								e_q     <= pos_inc(in.data.start_pos);
								state_q <= ST_SHIFT;
							end
							CMD_ERASE: begin
								after_q <= 1'b0;
								state_q <= ST_SHIFT;
							end
							CMD_LOOKUP, CMD_QUERY: state_q <= ST_LOOK;
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_SHIFT: begin
					if (i_q >= count_q) begin
						i_q <= '0;
						state_q <= ST_TIDY;
					end else begin
						if (req_q.command == CMD_INSERT) begin
							if (cur.first >= s_q) tab_q[ci].first <= pos_inc(cur.first);
							if (cur.last > s_q) tab_q[ci].last <= pos_inc(cur.last);
						end else begin
							if (cur.first > s_q) tab_q[ci].first <= cur.first - 1'b1;
							if (cur.last > s_q) tab_q[ci].last <= cur.last - 1'b1;
						end
						i_q <= i_q + 1'b1;
					end
				end
				ST_TIDY: begin
					if (i_q >= count_q) begin
						i_q <= '0;
						if (after_q) begin
							after_q <= 1'b0;
							state_q <= (e_q <= s_q) ? ST_DONE : ST_SCAN1;
						end else state_q <= ST_DONE;
					end else if (cur.first == cur.last) begin
						for (int j = 0; j < TableEntries - 1; j++)
							if (cnt_t'(j) >= i_q) tab_q[j] <= tab_q[j+1];
						count_q <= count_q - 1'b1;
						i_q <= '0;
					end else if (!has_next) begin
						i_q <= count_q;
					end else if (cur.kind == nxt.kind && cur.author == nxt.author &&
						cur.stamp == nxt.stamp && cur.last == nxt.first) begin
						for (int j = 0; j < TableEntries - 1; j++)
							if (cnt_t'(j) == i_q) tab_q[j] <= mrg;
							else if (cnt_t'(j) > i_q) tab_q[j] <= tab_q[j+1];
						count_q <= count_q - 1'b1;
						i_q <= '0;
					end else i_q <= i_q + 1'b1;
				end
				ST_SCAN1: begin
					if (i_q >= count_q) state_q <= ST_ADDNEW;
					else if (cur.first <= s_q && cur.last >= e_q && cur.kind == k_q) begin
						i_q <= '0;
						state_q <= ST_DONE;
					end else if (cur.first >= s_q) state_q <= ST_ADDNEW;
					else if (cur.last > s_q) begin
						tab_q[ci].last <= s_q;
						if (cur.last > e_q) begin
							if (count_q >= cnt_t'(TableEntries)) ovf_q <= 1'b1;
							else begin
								for (int j = 1; j < TableEntries; j++)
									if (cnt_t'(j) > i_q + 1'b1) tab_q[j] <= tab_q[j-1];
								tab_q[idx_t'(i_q + 1'b1)] <= '{e_q, cur.last, cur.kind,
									cur.author, cur.stamp};
								count_q <= count_q + 1'b1;
							end
						end
						i_q <= i_q + 1'b1;
					end else i_q <= i_q + 1'b1;
				end
				ST_ADDNEW: begin
					if (k_q != 2'd0) begin
						if (count_q >= cnt_t'(TableEntries)) ovf_q <= 1'b1;
						else begin
							for (int j = 1; j < TableEntries; j++)
								if (cnt_t'(j) > i_q) tab_q[j] <= tab_q[j-1];
							tab_q[ci] <= '{s_q, e_q, k_q, req_q.change_author,
								req_q.change_stamp};
							count_q <= count_q + 1'b1;
							i_q <= i_q + 1'b1;
						end
					end
					state_q <= ST_SCAN2;
				end
				ST_SCAN2: begin
					if (i_q >= count_q || cur.first >= e_q) begin
						i_q <= '0;
						state_q <= ST_TIDY;
					end else if (cur.first >= s_q && cur.last <= e_q) begin
						for (int j = 0; j < TableEntries - 1; j++)
							if (cnt_t'(j) >= i_q) tab_q[j] <= tab_q[j+1];
						count_q <= count_q - 1'b1;
					end else begin
						tab_q[ci].first <= e_q;
						i_q <= '0;
						state_q <= ST_TIDY;
					end
				end
				ST_LOOK: begin
					if (i_q >= count_q) state_q <= ST_DONE;
					else if (req_q.command == CMD_LOOKUP) begin
						if (s_q >= cur.first && s_q < cur.last) begin
							rsp_q.found_type   <= cur.kind;
							rsp_q.found_author <= cur.author;
							rsp_q.found_stamp  <= cur.stamp;
							state_q <= ST_DONE;
						end else i_q <= i_q + 1'b1;
					end else begin
						if (s_q < cur.last && e_q > cur.first) begin
							rsp_q.any_overlap <= 1'b1;
							state_q <= ST_DONE;
						end else i_q <= i_q + 1'b1;
					end
				end
				ST_DONE: begin
					rsp_q.table_overflow <= ovf_q;
					ovalid_q <= 1'b1;
					state_q  <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
